// ===== design/rcfd_pkg.sv =====
// Shared constants and types for the radio-control frame receiver decoder.
`timescale 1ns / 1ps

package rcfd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_GAP_THRESHOLD  = 2'd0;
  localparam logic [1:0] CFG_ELEVEN_BIT     = 2'd1;
  localparam logic [1:0] CFG_MANUAL_THRESH  = 2'd2;

  // Register reset values
  localparam logic [7:0]  GAP_THRESHOLD_RST = 8'd7;
  localparam logic        ELEVEN_BIT_RST    = 1'b0;
  localparam logic [10:0] MANUAL_THRESH_RST = 11'd600;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Gap counter saturation point
  localparam logic [7:0] GAP_MAX = 8'hFF;

  // Largest number of decoded words in one frame
  localparam int MAX_WORDS = 7;

  // Highest channel id that is recognised
  localparam logic [5:0] LAST_KNOWN_ID = 6'd6;

  // Channel roles
  localparam logic [5:0] CH_THROTTLE = 6'd0;
  localparam logic [5:0] CH_FIRST_AXIS = 6'd1;
  localparam logic [5:0] CH_LAST_AXIS = 6'd3;
  localparam logic [5:0] CH_MODE = 6'd4;

  // Half-scale of the value field in each mode
  localparam logic signed [11:0] HALF_10BIT = 12'sd512;
  localparam logic signed [11:0] HALF_11BIT = 12'sd1024;

  typedef logic [7:0] byte_t;

endpackage

// ===== design/rc_frame_receiver_channel_decoder_core.sv =====
// Top level of the radio-control frame receiver decoder: byte gathering and frame decode.
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid / in_stall): each transaction is either a received byte
// (in_action = 0, data on in_rx_byte) or a one-millisecond tick (in_action = 1).
// Ticks advance a saturating gap counter. A byte that arrives after a gap longer
// than the gap threshold closes the gathered frame; if exactly FRAME_BYTES bytes
// were gathered the frame is decoded into up to seven channel words, which leave
// on the output channel (out_valid / out_stall), one per transaction, the final
// one flagged by out_last together with the throttle and manual-mode values.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always ready;
// writes are meant to happen while the block is idle.
// A frame-closing byte starts a decode: the frame store has two synchronous read
// ports, so one word is read per cycle while the output is not stalled, then the
// new byte is written to entry 0 and the last word drains. The first word passes
// from the store reads through the read data register into the output register.
// in_stall is high while that decode runs.
// A stalled output holds its word and pauses the store reads; the input side
// keeps taking bytes and ticks once the decode has finished.
// Reset clears counters, stored channel values and configuration to defaults.
// The frame store itself is not cleared: only fully written frames are decoded.
module rc_frame_receiver_channel_decoder_core
  import rcfd_pkg::*;
#(
  parameter int FRAME_BYTES  = 16,
  parameter int HEADER_BYTES = 2,
  parameter int RX_LIMIT     = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [7:0]         in_rx_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_channel_id,
  output logic [10:0]        out_raw_value,
  output logic signed [16:0] out_centered_value,
  output logic               out_channel_known,
  output logic               out_manual_mode,
  output logic [7:0]         out_throttle,
  output logic               out_last,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int WORD_SLOTS = (FRAME_BYTES - HEADER_BYTES) / 2;
  localparam int WORD_COUNT = (WORD_SLOTS > MAX_WORDS) ? MAX_WORDS :
                              ((WORD_SLOTS < 0) ? 0 : WORD_SLOTS);
  localparam int LAST_IDX   = (WORD_COUNT > 0) ? WORD_COUNT - 1 : 0;
  localparam int AW         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int CNT_MAX    = (RX_LIMIT > FRAME_BYTES) ? RX_LIMIT : FRAME_BYTES;
  localparam int CW         = $clog2(CNT_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DRAIN
  } state_t;

  // configuration registers
  logic [7:0]  gap_threshold_r;
  logic        eleven_bit_r;
  logic [10:0] manual_thresh_r;

  // control state
  state_t      state_r;
  logic [7:0]  gap_counter_r;
  logic [CW-1:0] byte_count_r;
  logic [2:0]  issue_idx_r;
  logic        s1_valid_r;
  logic [2:0]  s1_idx_r;
  byte_t       pend_byte_r;
  logic [10:0] throttle_raw_r;
  logic [10:0] mode_raw_r;

  // frame store
  byte_t       frame_mem [FRAME_BYTES];
  byte_t       rd_a_r;
  byte_t       rd_b_r;

  // output registers
  logic               out_valid_r;
  logic [5:0]         out_id_r;
  logic [10:0]        out_raw_r;
  logic signed [16:0] out_centered_r;
  logic               out_known_r;
  logic               out_manual_r;
  logic [7:0]         out_throttle_r;
  logic               out_last_r;

  // handshake decode
  logic          in_acc;
  logic          is_byte;
  logic          is_tick;
  logic          gap_hit;
  logic [CW-1:0] cnt_base;
  logic          start_dec;
  logic          out_free;
  logic          advance;
  logic          rd_en;
  logic          load_out;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  byte_t         wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign is_byte   = in_acc && (in_action == ACT_BYTE);
  assign is_tick   = in_acc && (in_action == ACT_TICK);
  assign gap_hit   = (gap_counter_r > gap_threshold_r);
  assign cnt_base  = gap_hit ? '0 : byte_count_r;
  assign start_dec = is_byte && gap_hit && (byte_count_r == CW'(FRAME_BYTES)) &&
                     (WORD_COUNT > 0);

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = !s1_valid_r || out_free;
  assign rd_en     = (state_r == ST_READ) && advance;
  assign load_out  = s1_valid_r && out_free;

  // word addresses for the two read ports
  assign rd_addr_a = AW'(HEADER_BYTES + 2 * int'(issue_idx_r));
  assign rd_addr_b = AW'(HEADER_BYTES + 2 * int'(issue_idx_r) + 1);

  // write port: ordinary byte store, or the deferred first byte after a decode
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = in_rx_byte;
    if (state_r == ST_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = pend_byte_r;
    end else if (is_byte && !start_dec && (cnt_base < CW'(FRAME_BYTES))) begin
      wr_en   = 1'b1;
      wr_addr = cnt_base[AW-1:0];
    end
  end

  // frame store, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= frame_mem[rd_addr_a];
      rd_b_r <= frame_mem[rd_addr_b];
    end
  end

  // word split and scaling
  logic [15:0]        word;
  logic [5:0]         dec_id;
  logic [10:0]        dec_raw;
  logic signed [11:0] dec_diff;
  logic signed [16:0] dec_centered;
  logic               dec_known;
  logic               dec_last;
  logic [10:0]        thr_src_nxt;
  logic [10:0]        mode_src_nxt;
  logic [8:0]         thr_div;
  logic [7:0]         thr_sat;

  always_comb begin
    word = {rd_a_r, rd_b_r};
    if (eleven_bit_r) begin
      dec_raw  = word[10:0];
      dec_id   = {1'b0, word[15:11]};
      dec_diff = $signed({1'b0, dec_raw}) - HALF_11BIT;
    end else begin
      dec_raw  = {1'b0, word[9:0]};
      dec_id   = word[15:10];
      dec_diff = $signed({1'b0, dec_raw}) - HALF_10BIT;
    end
    // scale by 65536 / half: a shift of 6 or 7
    if ((dec_id >= CH_FIRST_AXIS) && (dec_id <= CH_LAST_AXIS)) begin
      dec_centered = eleven_bit_r ? (17'(dec_diff) <<< 6) : (17'(dec_diff) <<< 7);
    end else begin
      dec_centered = '0;
    end
    dec_known = (dec_id <= LAST_KNOWN_ID);
    dec_last  = (s1_idx_r == 3'(LAST_IDX));

    // stored channel values including the current word
    thr_src_nxt  = (dec_id == CH_THROTTLE) ? dec_raw : throttle_raw_r;
    mode_src_nxt = (dec_id == CH_MODE) ? dec_raw : mode_raw_r;
    thr_div      = eleven_bit_r ? {1'b0, thr_src_nxt[10:3]} : thr_src_nxt[10:2];
    thr_sat      = thr_div[8] ? 8'hFF : thr_div[7:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_threshold_r <= GAP_THRESHOLD_RST;
      eleven_bit_r    <= ELEVEN_BIT_RST;
      manual_thresh_r <= MANUAL_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAP_THRESHOLD: gap_threshold_r <= cfg_data[7:0];
        CFG_ELEVEN_BIT:    eleven_bit_r    <= cfg_data[0];
        CFG_MANUAL_THRESH: manual_thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      gap_counter_r  <= '0;
      byte_count_r   <= '0;
      issue_idx_r    <= '0;
      s1_valid_r     <= 1'b0;
      s1_idx_r       <= '0;
      throttle_raw_r <= '0;
      mode_raw_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // gathering side
      if (is_tick && (gap_counter_r != GAP_MAX)) begin
        gap_counter_r <= gap_counter_r + 8'd1;
      end
      if (is_byte) begin
        gap_counter_r <= '0;
        if (cnt_base < CW'(RX_LIMIT)) begin
          byte_count_r <= cnt_base + CW'(1);
        end else begin
          byte_count_r <= cnt_base;
        end
      end

      // decode sequencer
      case (state_r)
        ST_IDLE: begin
          if (start_dec) begin
            pend_byte_r <= in_rx_byte;
            issue_idx_r <= '0;
            state_r     <= ST_READ;
          end
        end
        ST_READ: begin
          if (rd_en) begin
            issue_idx_r <= issue_idx_r + 3'd1;
            if (issue_idx_r == 3'(LAST_IDX)) begin
              state_r <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!s1_valid_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // read data stage
      if (rd_en) begin
        s1_valid_r <= 1'b1;
        s1_idx_r   <= issue_idx_r;
      end else if (load_out) begin
        s1_valid_r <= 1'b0;
      end

      // output register
      if (load_out) begin
        out_valid_r    <= 1'b1;
        out_id_r       <= dec_id;
        out_raw_r      <= dec_raw;
        out_centered_r <= dec_centered;
        out_known_r    <= dec_known;
        out_last_r     <= dec_last;
        out_manual_r   <= dec_last && (mode_src_nxt > manual_thresh_r);
        out_throttle_r <= dec_last ? thr_sat : 8'd0;
        throttle_raw_r <= thr_src_nxt;
        mode_raw_r     <= mode_src_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_id     = out_id_r;
  assign out_raw_value      = out_raw_r;
  assign out_centered_value = out_centered_r;
  assign out_channel_known  = out_known_r;
  assign out_manual_mode    = out_manual_r;
  assign out_throttle       = out_throttle_r;
  assign out_last           = out_last_r;

  // checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !s1_valid_r)
    else $error("read stage busy while sequencer idle");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !wr_en)
    else $error("frame store written during decode reads");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CW'(CNT_MAX))
    else $error("byte count beyond limit");

  a_summary_on_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_throttle_r == 8'd0 && !out_manual_r))
    else $error("throttle or manual flag on a non-final word");

  a_decode_starts_reads: assert property (@(posedge clk) disable iff (!rst_n)
    start_dec |=> (state_r == ST_READ) && in_stall)
    else $error("frame close did not start decode");

endmodule
